### rtl/ftpr_pkg.sv
// shared types and constants of the frame table page replacement block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ftpr_pkg;
    localparam int FRAMES    = 16;
    localparam int PROCS     = 4;
    localparam int PAGE_BITS = 10;
    localparam int TIME_BITS = 32;
    localparam int FIDX_W    = $clog2(FRAMES);
    localparam int FCNT_W    = $clog2(FRAMES + 1);
    localparam int PROC_W    = (PROCS > 1) ? $clog2(PROCS) : 1;

    localparam logic [1:0] MODE_LRU  = 2'd0;
    localparam logic [1:0] MODE_RAND = 2'd1;
    localparam logic [1:0] MODE_LIFO = 2'd2;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    typedef struct packed {
        logic [1:0]  proc_id;
        logic [9:0]  page_num;
        logic [30:0] rand_value;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic [3:0]  frame_index;
        logic        evicted;
        logic [1:0]  victim_proc;
        logic [9:0]  victim_page;
        logic [31:0] victim_residency;
        logic [31:0] proc_faults;
        logic [31:0] victim_evictions;
        logic [31:0] victim_residency_sum;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_FREE, ST_VICTIM, ST_MOD, ST_UPDATE
    } t_state;
endpackage
`default_nettype wire

### rtl/ftpr_mod_unit.sv
// restoring remainder unit: 31-bit dividend modulo a small frame count
// depends on ftpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module ftpr_mod_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [30:0]                 i_dividend,
    input  wire logic [ftpr_pkg::FCNT_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [ftpr_pkg::FIDX_W-1:0]      o_rem
);
    logic [30:0] r_quo, n_quo;
    logic [ftpr_pkg::FCNT_W:0] r_rem, n_rem;
    logic [4:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic [ftpr_pkg::FCNT_W:0] w_trial;

    // one dividend bit shifted in per cycle while busy
    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        w_trial = {r_rem[ftpr_pkg::FCNT_W-1:0], r_quo[30]};
        o_done = 1'b0;
        if (i_start) begin
            n_quo = i_dividend; n_rem = '0; n_cnt = 5'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[29:0], 1'b0};
            n_rem = (w_trial >= {1'b0, i_divisor}) ? w_trial - {1'b0, i_divisor} : w_trial;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd30) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end
    assign o_rem = n_rem[ftpr_pkg::FIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_cnt <= n_cnt;
    end
endmodule
`default_nettype wire

### rtl/frame_table_page_replacement.sv
// top level: frame table, scan sequencer and per-process totals
// depends on ftpr_pkg and ftpr_mod_unit
`timescale 1ns / 1ps
`default_nettype none
// One reference is taken when i_start is high and o_busy low. The sequencer walks the
// active frames one per cycle for lookup, again (highest first) for a free frame, and
// once more for the LRU or LIFO victim; random mode runs a remainder unit instead.
// The result shows for one cycle on o_valid and cannot be stalled.
module frame_table_page_replacement (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire ftpr_pkg::t_in_beat    i_in,
    output logic                       o_busy,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [4:0]            i_cfg_data,
    output logic                       o_valid,
    output ftpr_pkg::t_out_beat        o_out
);
    localparam int FW = ftpr_pkg::FIDX_W;
    localparam int PW = ftpr_pkg::PROC_W;
    localparam int TW = ftpr_pkg::TIME_BITS;

    logic [1:0] r_mode;
    logic [4:0] r_frames;
    logic [TW-1:0] r_now;
    logic [ftpr_pkg::FRAMES-1:0] r_fvalid;
    logic [PW-1:0] r_owner [ftpr_pkg::FRAMES];
    logic [ftpr_pkg::PAGE_BITS-1:0] r_page [ftpr_pkg::FRAMES];
    logic [TW-1:0] r_load [ftpr_pkg::FRAMES];
    logic [TW-1:0] r_acc [ftpr_pkg::FRAMES];
    logic [31:0] r_faults [ftpr_pkg::PROCS];
    logic [31:0] r_evs [ftpr_pkg::PROCS];
    logic [31:0] r_ress [ftpr_pkg::PROCS];

    ftpr_pkg::t_state r_state, n_state;
    ftpr_pkg::t_in_beat r_req;
    logic [FW-1:0] r_idx, n_idx, r_best, n_best;
    logic r_hit, n_hit, r_ev, n_ev;
    logic [ftpr_pkg::FCNT_W-1:0] w_n;
    logic [FW-1:0] w_last;
    logic [PW-1:0] w_proc;
    logic w_match, w_better, w_mstart, w_mdone;
    logic [FW-1:0] w_mrem;
    logic [TW-1:0] w_res;
    logic [31:0] w_evs, w_ress, w_flt, w_ev1, w_rs1, w_fl1;
    logic [32:0] w_rsum;

    // clamp frame count
    always_comb begin
        if (r_frames == 5'd0) w_n = ftpr_pkg::FCNT_W'(1);
        else if (r_frames > 5'(ftpr_pkg::FRAMES)) w_n = ftpr_pkg::FCNT_W'(ftpr_pkg::FRAMES);
        else w_n = r_frames[ftpr_pkg::FCNT_W-1:0];
        w_last = FW'(w_n - ftpr_pkg::FCNT_W'(1));
    end
    assign w_proc = PW'(r_req.proc_id % ftpr_pkg::PROCS);

    // shared compare on the scanned frame
    assign w_match = r_fvalid[r_idx] && r_page[r_idx] == r_req.page_num
                     && r_owner[r_idx] == w_proc;
    assign w_better = (r_mode == ftpr_pkg::MODE_LIFO) ? (r_load[r_idx] > r_load[r_best])
                                                      : (r_acc[r_idx] <= r_acc[r_best]);

    ftpr_mod_unit u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_dividend(r_req.rand_value), .i_divisor(w_n),
        .o_done(w_mdone), .o_rem(w_mrem)
    );

    // sequencer
    always_comb begin
        n_state = r_state; n_idx = r_idx; n_best = r_best; n_hit = r_hit; n_ev = r_ev;
        w_mstart = 1'b0;
        unique case (r_state)
            ftpr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = ftpr_pkg::ST_LOOKUP; n_idx = '0; n_hit = 1'b0; n_ev = 1'b0;
                end
            end
            ftpr_pkg::ST_LOOKUP: begin
                if (w_match) begin
                    n_hit = 1'b1; n_best = r_idx; n_state = ftpr_pkg::ST_UPDATE;
                end else if (r_idx == w_last) begin
                    n_state = ftpr_pkg::ST_FREE;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end
            ftpr_pkg::ST_FREE: begin
                if (!r_fvalid[r_idx]) begin
                    n_best = r_idx; n_state = ftpr_pkg::ST_UPDATE;
                end else if (r_idx == '0) begin
                    n_ev = 1'b1; n_best = '0;
                    if (r_mode == ftpr_pkg::MODE_RAND) begin
                        w_mstart = 1'b1; n_state = ftpr_pkg::ST_MOD;
                    end else if (w_last == '0) begin
                        n_state = ftpr_pkg::ST_UPDATE;
                    end else begin
                        n_idx = FW'(1); n_state = ftpr_pkg::ST_VICTIM;
                    end
                end else begin
                    n_idx = r_idx - FW'(1);
                end
            end
            ftpr_pkg::ST_VICTIM: begin
                if (w_better) n_best = r_idx;
                if (r_idx == w_last) n_state = ftpr_pkg::ST_UPDATE;
                else n_idx = r_idx + FW'(1);
            end
            ftpr_pkg::ST_MOD: begin
                if (w_mdone) begin
                    n_best = w_mrem; n_state = ftpr_pkg::ST_UPDATE;
                end
            end
            ftpr_pkg::ST_UPDATE: n_state = ftpr_pkg::ST_IDLE;
            default: n_state = ftpr_pkg::ST_IDLE;
        endcase
    end

    // totals arithmetic for the update step
    always_comb begin
        w_res  = r_now - r_load[r_best];
        w_evs  = r_evs[r_owner[r_best]];
        w_ress = r_ress[r_owner[r_best]];
        w_flt  = r_faults[w_proc];
        w_ev1  = (w_evs == '1) ? w_evs : w_evs + 32'd1;
        w_rsum = {1'b0, w_ress} + {{(33-TW){1'b0}}, w_res};
        w_rs1  = w_rsum[32] ? '1 : w_rsum[31:0];
        w_fl1  = (w_flt == '1) ? w_flt : w_flt + 32'd1;
    end

    assign o_busy = (r_state != ftpr_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftpr_pkg::ST_IDLE;
            r_mode <= ftpr_pkg::MODE_LRU;
            r_frames <= 5'd16;
            r_now <= TW'(1);
            r_fvalid <= '0;
            o_valid <= 1'b0;
            for (int p = 0; p < ftpr_pkg::PROCS; p++) begin
                r_faults[p] <= '0; r_evs[p] <= '0; r_ress[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_index == ftpr_pkg::REG_MODE) r_mode <= i_cfg_data[1:0];
                else r_frames <= i_cfg_data;
            end
            // commit one reference
            if (r_state == ftpr_pkg::ST_UPDATE) begin
                o_valid <= 1'b1;
                r_now <= r_now + TW'(1);
                o_out.hit <= r_hit;
                o_out.frame_index <= 4'(r_best);
                o_out.evicted <= r_ev;
                // victim fields read zero when nothing was evicted
                o_out.victim_proc <= r_ev ? 2'(r_owner[r_best]) : 2'd0;
                o_out.victim_page <= r_ev ? 10'(r_page[r_best]) : 10'd0;
                o_out.victim_residency <= r_ev ? 32'(w_res) : 32'd0;
                o_out.victim_evictions <= r_ev ? w_ev1 : 32'd0;
                o_out.victim_residency_sum <= r_ev ? w_rs1 : 32'd0;
                o_out.proc_faults <= r_hit ? w_flt : w_fl1;
                r_acc[r_best] <= r_now;
                if (!r_hit) begin
                    r_fvalid[r_best] <= 1'b1;
                    r_owner[r_best] <= w_proc;
                    r_page[r_best] <= r_req.page_num;
                    r_load[r_best] <= r_now;
                    r_faults[w_proc] <= w_fl1;
                end
                if (r_ev) begin
                    r_evs[r_owner[r_best]] <= w_ev1;
                    r_ress[r_owner[r_best]] <= w_rs1;
                end
            end
        end
        if (r_state == ftpr_pkg::ST_IDLE && i_start) r_req <= i_in;
        r_idx <= n_idx; r_best <= n_best; r_hit <= n_hit; r_ev <= n_ev;
    end
endmodule
`default_nettype wire
